// File: rtl/bmp_stream_to_rgb565_top_macros.svh
// ----------------------------------------------------------------------------
// BMP to RGB565 assertion macros
// Shared concurrent assertion forms for the converter RTL.
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_TO_RGB565_TOP_MACROS_SVH
`define BMP_STREAM_TO_RGB565_TOP_MACROS_SVH

// same-cycle implication
`define BMP565_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define BMP565_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// File: rtl/bmp565_pkg.sv
// ----------------------------------------------------------------------------
// BMP to RGB565 package
// Phase type, status codes, header layout and field widths.
// ----------------------------------------------------------------------------
package bmp565_pkg;

   localparam int INDEX_BITS = 22;
   localparam int COLOR_BITS = 16;
   localparam int DIM_BITS   = 12;
   localparam int STATUS_BITS = 2;

   localparam int HEADER_BYTES = 54;
   localparam int POS_OFFSET   = 10;
   localparam int POS_WIDTH    = 18;
   localparam int POS_HEIGHT   = 22;
   localparam int POS_DEPTH    = 28;

   localparam logic [15:0] DEPTH_INDEXED = 16'd8;
   localparam logic [15:0] DEPTH_BGR     = 16'd24;

   typedef logic [STATUS_BITS-1:0] status_type;

   localparam status_type STATUS_PIXEL = 2'd0;
   localparam status_type STATUS_LAST  = 2'd1;
   localparam status_type STATUS_DEPTH = 2'd2;
   localparam status_type STATUS_SIZE  = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PALETTE,
      PH_PIXELS,
      PH_IDLE
   } phase_type;

endpackage

// File: rtl/bmp565_if.sv
// ----------------------------------------------------------------------------
// BMP to RGB565 channel interfaces
// Valid/ready channels for file bytes in and pixel beats out.
// ----------------------------------------------------------------------------
interface bmp565_req_if;
   import bmp565_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       start_of_file;

   modport source (output valid, output file_byte, output start_of_file, input ready);
   modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface bmp565_rsp_if;
   import bmp565_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] pixel_index;
   logic [COLOR_BITS-1:0] color;
   status_type            status;
   logic [DIM_BITS-1:0]   image_width;
   logic [DIM_BITS-1:0]   image_height;

   modport source (output valid, output pixel_index, output color, output status,
                   output image_width, output image_height, input ready);
   modport sink   (input valid, input pixel_index, input color, input status,
                   input image_width, input image_height, output ready);
endinterface

// File: rtl/bmp565_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bmp565_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bmp_stream_to_rgb565_top.sv
// ----------------------------------------------------------------------------
// BMP stream to RGB565 converter
// Parses a BMP byte stream, loads the palette into RAM and emits RGB565 pixels.
// ----------------------------------------------------------------------------
// Path: a pixel beat goes through the stage-1 register, then the output register.
// Throughput: one byte per cycle while stage 1 can pass its beat on; the parser
// state updates per accepted byte, one palette RAM read per indexed pixel.
// Reset: synchronous, clears the parser and both pipeline stages; palette RAM
// contents are kept and gated by the loaded-entry count, so there is no sweep.
`include "bmp_stream_to_rgb565_top_macros.svh"

module bmp_stream_to_rgb565_top #(
   parameter int MAX_WIDTH       = 2048,
   parameter int MAX_HEIGHT      = 2048,
   parameter int PALETTE_ENTRIES = 256
) (
   input logic          clock,
   input logic          reset,
   bmp565_req_if.sink   req_chan,
   bmp565_rsp_if.source rsp_chan
);
   import bmp565_pkg::*;

   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int HB  = $clog2(MAX_HEIGHT + 1);
   localparam int LB  = $clog2(PALETTE_ENTRIES + 1);
   localparam int PAB = $clog2(PALETTE_ENTRIES);
   localparam int PB  = HB + WB;

   typedef struct packed {
      logic [31:0]     pos;
      logic [31:0]     offset;
      logic [31:0]     raw_w;
      logic [31:0]     raw_h;
      logic [15:0]     raw_d;
      logic [WB-1:0]   width;
      logic [HB-1:0]   height;
      logic            top;
      logic            is24;
      logic [LB-1:0]   loaded;
      logic [WB-1:0]   col;
      logic [HB-1:0]   row;
      logic [1:0]      bip;
      logic [15:0]     partial;
      logic [1:0]      pad;
   } parser_type;

   localparam parser_type PARSER_RESET = '0;

   phase_type  phase_ff, phase_in, phase_cur;
   parser_type st_ff, st_in, cur;

   logic       req_accept, out_load;
   logic [7:0] b;

   logic        hdr_last, depth_ok, size_ok, pal_byte, in_pix, pad_skip, px_done;
   logic        col_end, row_end;
   logic [31:0] mag;
   logic [1:0]  pix_bip, pad_amt, row_bytes;
   logic [15:0] pix_partial;
   logic [WB-1:0] col_next;
   logic [HB-1:0] row_next;

   logic             pal_we, pal_re, ram_we;
   logic [15:0]      ram_rdata;

   logic             s0_emit, s0_pal;
   status_type       s0_status;
   logic [HB-1:0]    s0_row;
   logic [WB-1:0]    s0_col, s0_width;
   logic [HB-1:0]    s0_height;
   logic [15:0]      s0_color;

   logic             s1_valid_ff, s1_pal_ff;
   status_type       s1_status_ff;
   logic [HB-1:0]    s1_row_ff, s1_height_ff;
   logic [WB-1:0]    s1_col_ff, s1_width_ff;
   logic [15:0]      s1_color_ff;
   logic [PB-1:0]    s1_prod;

   logic                  rsp_valid_ff;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [COLOR_BITS-1:0] rsp_color_ff, rsp_color_in;
   status_type            rsp_status_ff;
   logic [DIM_BITS-1:0]   rsp_width_ff, rsp_width_in, rsp_height_ff, rsp_height_in;

   // handshake
   assign out_load       = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || out_load;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign b              = req_chan.file_byte;

   // restart folds into the current view of the state
   assign phase_cur = req_chan.start_of_file ? PH_HEADER : phase_ff;
   assign cur       = req_chan.start_of_file ? PARSER_RESET : st_ff;

   assign hdr_last = cur.pos == 32'(HEADER_BYTES - 1);
   assign depth_ok = (cur.raw_d == DEPTH_INDEXED) || (cur.raw_d == DEPTH_BGR);
   assign mag      = cur.raw_h[31] ? (32'd0 - cur.raw_h) : cur.raw_h;
   assign size_ok  = (cur.raw_w != 32'd0) && (cur.raw_w <= 32'(MAX_WIDTH)) &&
                     (mag != 32'd0) && (mag <= 32'(MAX_HEIGHT));
   assign pal_byte = cur.pos < cur.offset;
   assign in_pix   = (phase_cur == PH_PIXELS) || ((phase_cur == PH_PALETTE) && !pal_byte);
   assign pix_bip     = (phase_cur == PH_PALETTE) ? 2'd0 : cur.bip;
   assign pix_partial = (phase_cur == PH_PALETTE) ? 16'd0 : cur.partial;
   assign pad_skip = cur.pad != 2'd0;
   assign px_done  = in_pix && !pad_skip && (!cur.is24 || (pix_bip == 2'd2));
   assign col_next = cur.col + 1'b1;
   assign row_next = cur.row + 1'b1;
   assign col_end  = col_next == cur.width;
   assign row_end  = col_end && (row_next == cur.height);
   assign row_bytes = cur.is24 ? 2'(cur.width[1:0] * 2'd3) : cur.width[1:0];
   assign pad_amt   = 2'd0 - row_bytes;

   // next phase
   always_comb begin
      phase_in = phase_cur;
      unique case (phase_cur)
         PH_HEADER: begin
            if (hdr_last) begin
               phase_in = (depth_ok && size_ok) ? PH_PALETTE : PH_IDLE;
            end
         end
         PH_PALETTE: begin
            if (!pal_byte) begin
               phase_in = (px_done && row_end) ? PH_IDLE : PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            if (px_done && row_end) begin
               phase_in = PH_IDLE;
            end
         end
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // parser datapath and stage-0 beat
   always_comb begin
      logic [1:0] lane;
      logic [1:0] k;
      lane = cur.pos[1:0] - 2'(POS_OFFSET);
      k    = cur.pos[1:0] - 2'(HEADER_BYTES);
      st_in = cur;
      st_in.pos = (cur.pos == '1) ? cur.pos : cur.pos + 32'd1;
      pal_we    = 1'b0;
      pal_re    = 1'b0;
      s0_emit   = 1'b0;
      s0_pal    = 1'b0;
      s0_status = STATUS_PIXEL;
      s0_row    = '0;
      s0_col    = '0;
      s0_width  = '0;
      s0_height = '0;
      s0_color  = '0;
      unique case (phase_cur)
         PH_HEADER: begin
            if (cur.pos >= 32'(POS_OFFSET) && cur.pos <= 32'(POS_OFFSET + 3)) begin
               st_in.offset = cur.offset | (32'(b) << {lane, 3'b000});
            end else if (cur.pos >= 32'(POS_WIDTH) && cur.pos <= 32'(POS_WIDTH + 3)) begin
               st_in.raw_w = cur.raw_w | (32'(b) << {lane, 3'b000});
            end else if (cur.pos >= 32'(POS_HEIGHT) && cur.pos <= 32'(POS_HEIGHT + 3)) begin
               st_in.raw_h = cur.raw_h | (32'(b) << {lane, 3'b000});
            end else if (cur.pos >= 32'(POS_DEPTH) && cur.pos <= 32'(POS_DEPTH + 1)) begin
               st_in.raw_d = cur.raw_d | (16'(b) << {lane[0], 3'b000});
            end
            if (hdr_last) begin
               if (!depth_ok) begin
                  s0_emit   = 1'b1;
                  s0_status = STATUS_DEPTH;
               end else if (!size_ok) begin
                  s0_emit   = 1'b1;
                  s0_status = STATUS_SIZE;
               end else begin
                  st_in.width  = WB'(cur.raw_w);
                  st_in.height = HB'(mag);
                  st_in.top    = cur.raw_h[31];
                  st_in.is24   = cur.raw_d == DEPTH_BGR;
               end
            end
         end
         PH_PALETTE, PH_PIXELS: begin
            if (!in_pix) begin
               unique case (k)
                  2'd0: st_in.partial = {11'd0, b[7:3]};
                  2'd1: st_in.partial = cur.partial | {5'd0, b[7:2], 5'd0};
                  2'd2: st_in.partial = cur.partial | {b[7:3], 11'd0};
                  2'd3: begin
                     if (cur.loaded < LB'(PALETTE_ENTRIES)) begin
                        pal_we       = 1'b1;
                        st_in.loaded = cur.loaded + 1'b1;
                     end
                  end
               endcase
            end else begin
               st_in.bip     = pix_bip;
               st_in.partial = pix_partial;
               if (pad_skip) begin
                  st_in.pad = cur.pad - 2'd1;
               end else if (!cur.is24) begin
                  pal_re = 1'b1;
                  s0_pal = LB'(b) < cur.loaded;
               end else begin
                  unique case (pix_bip)
                     2'd0: begin
                        st_in.partial = {11'd0, b[7:3]};
                        st_in.bip     = 2'd1;
                     end
                     2'd1: begin
                        st_in.partial = pix_partial | {5'd0, b[7:2], 5'd0};
                        st_in.bip     = 2'd2;
                     end
                     default: begin
                        s0_color  = pix_partial | {b[7:3], 11'd0};
                        st_in.bip = 2'd0;
                     end
                  endcase
               end
               if (px_done) begin
                  s0_emit   = 1'b1;
                  s0_row    = cur.top ? cur.row : HB'(cur.height - cur.row - 1'b1);
                  s0_col    = cur.col;
                  s0_width  = cur.width;
                  s0_height = cur.height;
                  if (col_end) begin
                     st_in.col = '0;
                     st_in.row = row_next;
                     if (row_end) begin
                        s0_status = STATUS_LAST;
                     end else begin
                        st_in.pad = pad_amt;
                     end
                  end else begin
                     st_in.col = col_next;
                  end
               end
            end
         end
         PH_IDLE: begin
            st_in.pos = (cur.pos == '1) ? cur.pos : cur.pos + 32'd1;
         end
      endcase
   end

   assign ram_we = req_accept && pal_we;

   bmp565_ram #(
      .WIDTH (COLOR_BITS),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur.loaded[PAB-1:0]),
      .wr_data (cur.partial),
      .rd_en   (req_accept && pal_re),
      .rd_addr (PAB'(b)),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         st_ff    <= PARSER_RESET;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         st_ff    <= st_in;
      end
   end

   // stage 1: waits on palette read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= s0_emit;
      end else if (out_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && s0_emit) begin
         s1_pal_ff    <= s0_pal;
         s1_status_ff <= s0_status;
         s1_row_ff    <= s0_row;
         s1_col_ff    <= s0_col;
         s1_width_ff  <= s0_width;
         s1_height_ff <= s0_height;
         s1_color_ff  <= s0_color;
      end
   end

   assign s1_prod       = PB'(s1_row_ff) * PB'(s1_width_ff) + PB'(s1_col_ff);
   assign rsp_index_in  = INDEX_BITS'(s1_prod);
   assign rsp_color_in  = s1_pal_ff ? ram_rdata : s1_color_ff;
   assign rsp_width_in  = DIM_BITS'(s1_width_ff);
   assign rsp_height_in = DIM_BITS'(s1_height_ff);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_index_ff  <= rsp_index_in;
         rsp_color_ff  <= rsp_color_in;
         rsp_status_ff <= s1_status_ff;
         rsp_width_ff  <= rsp_width_in;
         rsp_height_ff <= rsp_height_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pixel_index  = rsp_index_ff;
   assign rsp_chan.color        = rsp_color_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.image_width  = rsp_width_ff;
   assign rsp_chan.image_height = rsp_height_ff;

   `BMP565_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !out_load, s1_valid_ff)
   `BMP565_ASSERT_NEXT(a_pal_count, clock, reset, ram_we, st_ff.loaded == $past(cur.loaded) + 1'b1)
   `BMP565_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == STATUS_DEPTH || rsp_status_ff == STATUS_SIZE), rsp_index_ff == '0 && rsp_color_ff == '0 && rsp_width_ff == '0)
   `BMP565_ASSERT_NEXT(a_last_idle, clock, reset, req_accept && s0_emit && s0_status == STATUS_LAST, phase_ff == PH_IDLE)

endmodule

// File: tb/bmp565_tb_pkg.sv
// ----------------------------------------------------------------------------
// BMP to RGB565 frame checker
// Decodes the accepted file bytes into the pixel beats the converter owes
// and compares each beat that leaves the block with the oldest one due.
// ----------------------------------------------------------------------------
package bmp565_tb_pkg;
   import bmp565_pkg::*;

   typedef struct packed {
      logic [INDEX_BITS-1:0] pixel_index;
      logic [COLOR_BITS-1:0] color;
      status_type            status;
      logic [DIM_BITS-1:0]   image_width;
      logic [DIM_BITS-1:0]   image_height;
   } pixel_beat_t;

   class bmp565_frame_checker;
      int unsigned max_width;
      int unsigned max_height;
      int unsigned palette_entries;

      logic [31:0] byte_pos;
      phase_type   phase;
      logic [31:0] data_offset;
      logic [31:0] raw_width;
      logic [31:0] raw_height;
      logic [15:0] raw_depth;
      logic [31:0] width_held;
      logic [31:0] height_held;
      bit          top_down;
      logic [15:0] depth_held;
      logic [15:0] palette [256];
      int unsigned loaded;
      int unsigned column;
      int unsigned raster_row;
      int unsigned byte_in_pixel;
      logic [15:0] partial;
      int unsigned pad_left;

      pixel_beat_t pending_pixels[$];
      int unsigned errors;

      function new(int unsigned mw, int unsigned mh, int unsigned entries);
         max_width = mw;
         max_height = mh;
         palette_entries = entries;
         errors = 0;
         foreach (palette[i]) palette[i] = '0;
         restart();
      endfunction

      function void restart();
         byte_pos = '0;
         phase = PH_HEADER;
         data_offset = '0;
         raw_width = '0;
         raw_height = '0;
         raw_depth = '0;
         width_held = '0;
         height_held = '0;
         top_down = 1'b0;
         depth_held = '0;
         loaded = 0;
         column = 0;
         raster_row = 0;
         byte_in_pixel = 0;
         partial = '0;
         pad_left = 0;
      endfunction

      function void close_header();
         logic [31:0] mag;
         pixel_beat_t beat;
         beat = '0;
         if (raw_depth != DEPTH_INDEXED && raw_depth != DEPTH_BGR) begin
            phase = PH_IDLE;
            beat.status = STATUS_DEPTH;
            pending_pixels.push_back(beat);
            return;
         end
         mag = raw_height[31] ? (~raw_height + 32'd1) : raw_height;
         if (raw_width == 0 || raw_width > max_width || mag == 0 || mag > max_height) begin
            phase = PH_IDLE;
            beat.status = STATUS_SIZE;
            pending_pixels.push_back(beat);
            return;
         end
         width_held = raw_width;
         height_held = mag;
         top_down = raw_height[31];
         depth_held = raw_depth;
         phase = PH_PALETTE;
      endfunction

      function void take_byte(input logic [7:0] b, input logic first);
         logic [31:0] at;
         logic [31:0] rel;
         logic [31:0] row_no;
         logic [15:0] color;
         int unsigned bytes_per_pixel;
         pixel_beat_t beat;
         if (first) restart();
         at = byte_pos;
         if (byte_pos != '1) byte_pos++;

         if (phase == PH_HEADER) begin
            if (at >= POS_OFFSET && at < POS_OFFSET + 4)
               data_offset[8*(at-POS_OFFSET) +: 8] = b;
            else if (at >= POS_WIDTH && at < POS_WIDTH + 4)
               raw_width[8*(at-POS_WIDTH) +: 8] = b;
            else if (at >= POS_HEIGHT && at < POS_HEIGHT + 4)
               raw_height[8*(at-POS_HEIGHT) +: 8] = b;
            else if (at >= POS_DEPTH && at < POS_DEPTH + 2)
               raw_depth[8*(at-POS_DEPTH) +: 8] = b;
            if (at == HEADER_BYTES - 1) close_header();
            return;
         end

         if (phase == PH_PALETTE) begin
            if (at < data_offset) begin
               rel = at - HEADER_BYTES;
               case (rel[1:0])
                  2'd0: partial = {11'd0, b[7:3]};
                  2'd1: partial[10:5] = b[7:2];
                  2'd2: partial[15:11] = b[7:3];
                  default: begin
                     if (loaded < palette_entries) begin
                        palette[loaded] = partial;
                        loaded++;
                     end
                  end
               endcase
               return;
            end
            phase = PH_PIXELS;
            byte_in_pixel = 0;
            partial = '0;
         end
         if (phase != PH_PIXELS) return;

         if (pad_left > 0) begin
            pad_left--;
            return;
         end
         if (depth_held == DEPTH_INDEXED) begin
            color = (b < loaded) ? palette[b] : '0;
            bytes_per_pixel = 1;
         end else begin
            if (byte_in_pixel == 0) begin
               partial = {11'd0, b[7:3]};
               byte_in_pixel = 1;
               return;
            end
            if (byte_in_pixel == 1) begin
               partial[10:5] = b[7:2];
               byte_in_pixel = 2;
               return;
            end
            color = partial | {b[7:3], 11'd0};
            byte_in_pixel = 0;
            bytes_per_pixel = 3;
         end

         row_no = top_down ? raster_row : height_held - 1 - raster_row;
         rel = row_no * width_held + column;
         beat.pixel_index = rel[INDEX_BITS-1:0];
         beat.color = color;
         beat.status = STATUS_PIXEL;
         beat.image_width = width_held[DIM_BITS-1:0];
         beat.image_height = height_held[DIM_BITS-1:0];
         column++;
         if (column >= width_held) begin
            column = 0;
            raster_row++;
            if (raster_row >= height_held) begin
               beat.status = STATUS_LAST;
               phase = PH_IDLE;
            end else begin
               pad_left = (4 - ((width_held * bytes_per_pixel) % 4)) % 4;
            end
         end
         pending_pixels.push_back(beat);
      endfunction

      function void check_pixel(input pixel_beat_t got);
         pixel_beat_t want;
         if (pending_pixels.size() == 0) begin
            $error("pixel beat with nothing due: pixel_index %0d status %0d",
                   got.pixel_index, got.status);
            errors++;
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
            errors++;
         end
         if (got.color !== want.color) begin
            $error("color: expected %h, got %h", want.color, got.color);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.image_width !== want.image_width) begin
            $error("image_width: expected %0d, got %0d", want.image_width, got.image_width);
            errors++;
         end
         if (got.image_height !== want.image_height) begin
            $error("image_height: expected %0d, got %0d", want.image_height, got.image_height);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: tb/bmp_stream_to_rgb565_top_tb.sv
// ----------------------------------------------------------------------------
// BMP to RGB565 converter testbench
// Streams directed and random BMP files (valid images, broken headers, cut
// files) through the converter with random gaps on both channels and checks
// every pixel beat against a decoder of its own.
// ----------------------------------------------------------------------------
module bmp_stream_to_rgb565_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bmp565_pkg::*;
   import bmp565_tb_pkg::*;

   localparam int          MAX_W       = 2048;
   localparam int          MAX_H       = 2048;
   localparam int          ENTRIES     = 256;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned BYTE_TARGET = 1750;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned NO_CAP      = 100000;
   localparam int unsigned TAIL_CYCLES = 20;

   logic clock;
   logic reset;

   bmp565_req_if req_chan();
   bmp565_rsp_if rsp_chan();

   bmp_stream_to_rgb565_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bmp565_frame_checker frames = new(MAX_W, MAX_H, ENTRIES);

   logic [7:0]  file_bytes[$];
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int unsigned cycles = 0;
   int unsigned sent_bytes = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         frames.check_pixel({rsp_chan.pixel_index, rsp_chan.color, rsp_chan.status,
                             rsp_chan.image_width, rsp_chan.image_height});
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_index(input int unsigned entries);
      int unsigned limit;
      limit = (entries + 1 > 255) ? 255 : entries + 1;
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, limit);
      return $urandom_range(0, 255);
   endfunction

   // pixel beat sink: random stalls, one long hold on request
   initial begin
      int unsigned g;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (calm) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               stall_left = g - 1;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic first);
      int unsigned gap;
      req_chan.valid <= 1'b1;
      req_chan.file_byte <= value;
      req_chan.start_of_file <= first;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      frames.take_byte(value, first);
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (frames.pending_pixels.size() != 0);
   endtask

   task automatic run_file(input int unsigned w, input int h, input int unsigned depth,
                           input longint unsigned offset, input int unsigned cap);
      int unsigned mag;
      int unsigned bpp;
      int unsigned entries;
      int unsigned pad;
      int unsigned r;
      int unsigned c;
      longint unsigned p;
      bit good;
      file_bytes.delete();
      repeat (HEADER_BYTES) file_bytes.push_back($urandom_range(0, 255));
      for (int j = 0; j < 4; j++) begin
         file_bytes[POS_OFFSET+j] = offset >> (8 * j);
         file_bytes[POS_WIDTH+j] = w >> (8 * j);
         file_bytes[POS_HEIGHT+j] = h >> (8 * j);
      end
      file_bytes[POS_DEPTH] = depth;
      file_bytes[POS_DEPTH+1] = depth >> 8;
      mag = (h < 0) ? -h : h;
      good = (depth == DEPTH_INDEXED || depth == DEPTH_BGR) && w >= 1 && w <= MAX_W &&
             mag >= 1 && mag <= MAX_H;
      if (good) begin
         for (p = HEADER_BYTES; p < offset && file_bytes.size() < cap; p++)
            file_bytes.push_back($urandom_range(0, 255));
         entries = 0;
         if (offset > HEADER_BYTES)
            entries = ((offset - HEADER_BYTES) / 4 > ENTRIES) ? ENTRIES
                                                              : (offset - HEADER_BYTES) / 4;
         bpp = (depth == DEPTH_INDEXED) ? 1 : 3;
         pad = (4 - (w * bpp) % 4) % 4;
         for (r = 0; r < mag && file_bytes.size() < cap; r++) begin
            for (c = 0; c < w * bpp && file_bytes.size() < cap; c++)
               file_bytes.push_back(bpp == 1 ? pick_index(entries) : $urandom_range(0, 255));
            repeat (pad) file_bytes.push_back($urandom_range(0, 255));
         end
      end
      repeat ($urandom_range(0, 3)) file_bytes.push_back($urandom_range(0, 255));
      while (file_bytes.size() > cap) void'(file_bytes.pop_back());
      foreach (file_bytes[i]) begin
         send_byte(file_bytes[i], i == 0);
         sent_bytes++;
      end
   endtask

   task automatic run_random_file();
      int unsigned kind;
      int unsigned w;
      int h;
      int unsigned depth;
      longint unsigned offset;
      int unsigned cap;
      kind = $urandom_range(0, 19);
      depth = $urandom_range(0, 1) ? DEPTH_INDEXED : DEPTH_BGR;
      w = $urandom_range(1, 7);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 1)) h = -h;
      case ($urandom_range(0, 9))
         0: offset = $urandom_range(0, HEADER_BYTES);
         1, 2, 3, 4, 5, 6:
            offset = (depth == DEPTH_BGR) ? HEADER_BYTES
                                          : HEADER_BYTES + 4 * $urandom_range(0, 20);
         default: offset = HEADER_BYTES + 4 * $urandom_range(0, 20) + $urandom_range(0, 3);
      endcase
      cap = NO_CAP;
      if (kind >= 15 && kind < 17) begin
         depth = ($urandom_range(0, 1)) ? $urandom_range(0, 65535) : depth;
         w = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(2040, 2100);
         h = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(2040, 2100);
         if ($urandom_range(0, 1)) h = -h;
         cap = HEADER_BYTES + $urandom_range(0, 40);
      end else if (kind >= 17) begin
         if ($urandom_range(0, 2) == 0) offset = $urandom;
         cap = $urandom_range(1, 90);
      end
      run_file(w, h, depth, offset, cap);
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.file_byte <= '0;
      req_chan.start_of_file <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_file(1, 1, DEPTH_BGR, HEADER_BYTES, NO_CAP);
      run_file(3, 2, DEPTH_BGR, HEADER_BYTES, NO_CAP);
      run_file(2, -3, DEPTH_BGR, HEADER_BYTES, NO_CAP);
      run_file(5, 2, DEPTH_INDEXED, HEADER_BYTES + 16, NO_CAP);
      run_file(7, -2, DEPTH_INDEXED, HEADER_BYTES + 42, NO_CAP);
      run_file(4, 3, DEPTH_INDEXED, HEADER_BYTES + 4 * 258 + 2, NO_CAP);
      run_file(4, 1, DEPTH_INDEXED, 20, NO_CAP);
      run_file(3, 1, DEPTH_BGR, 0, NO_CAP);
      run_file(4, 2, 16, HEADER_BYTES, HEADER_BYTES + 4);
      run_file(0, 0, 0, HEADER_BYTES, HEADER_BYTES + 2);
      run_file(4, 2, 32, HEADER_BYTES, HEADER_BYTES);
      run_file(4, 2, 16'hFF08, HEADER_BYTES, HEADER_BYTES + 3);
      run_file(0, 5, DEPTH_BGR, HEADER_BYTES, HEADER_BYTES + 3);
      run_file(MAX_W + 1, 1, DEPTH_INDEXED, HEADER_BYTES, HEADER_BYTES + 3);
      run_file(32'hFFFF_FFFF, 1, DEPTH_INDEXED, HEADER_BYTES, HEADER_BYTES);
      run_file(3, 0, DEPTH_BGR, HEADER_BYTES, HEADER_BYTES + 3);
      run_file(3, MAX_H + 1, DEPTH_BGR, HEADER_BYTES, HEADER_BYTES + 3);
      run_file(3, -(MAX_H + 1), DEPTH_INDEXED, HEADER_BYTES, HEADER_BYTES + 3);
      run_file(3, int'(32'h8000_0000), DEPTH_BGR, HEADER_BYTES, HEADER_BYTES + 3);
      run_file(MAX_W, MAX_H, DEPTH_BGR, HEADER_BYTES, HEADER_BYTES + 120);
      run_file(MAX_W, -MAX_H, DEPTH_INDEXED, HEADER_BYTES + 8, HEADER_BYTES + 70);
      run_file(1, MAX_H, DEPTH_INDEXED, HEADER_BYTES + 4, HEADER_BYTES + 44);
      run_file(4, 2, DEPTH_BGR, HEADER_BYTES, 30);

      // hold the sink long enough to back the block up
      hold_request = 1'b1;
      run_file(6, 4, DEPTH_BGR, HEADER_BYTES, NO_CAP);
      drain();

      sent_bytes = 0;
      while (sent_bytes < BYTE_TARGET) begin
         calm = ($urandom_range(0, 4) == 0);
         run_random_file();
         if ($urandom_range(0, 7) == 0) drain();
      end
      calm = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (frames.errors == 0 && frames.pending_pixels.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: bmp_stream_to_rgb565_top.f
+incdir+rtl
rtl/bmp565_pkg.sv
rtl/bmp565_if.sv
rtl/bmp565_ram.sv
rtl/bmp_stream_to_rgb565_top.sv
tb/bmp565_tb_pkg.sv
tb/bmp_stream_to_rgb565_top_tb.sv
